FILE: design/mxp_pkg.sv
// ----------------------------------------------------------------------------
// mxp_pkg: shared types and constants for modular exponentiation
// Field widths, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mxp_pkg;

  // Width of every payload and configuration field at the ports
  localparam int unsigned FIELD_W   = 64;
  // Width of the configuration register index
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = 2'd0;
  localparam cfg_idx_t REG_EXPONENT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } mxp_state_t;

endpackage : mxp_pkg

`default_nettype wire

FILE: design/mxp_cell.sv
// ----------------------------------------------------------------------------
// mxp_cell: one stage of the multiplier-operand bit line
// Holds one operand bit; loads in parallel or takes its neighbour's bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mxp_cell (
  input  wire logic clk,
  input  wire logic load,
  input  wire logic load_bit,
  input  wire logic prev_bit,
  output logic      bit_q
);

  logic bit_r;
  logic bit_nxt;

  // load a fresh operand bit, otherwise advance towards the head
  assign bit_nxt = load ? load_bit : prev_bit;

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_q = bit_r;

endmodule : mxp_cell

`default_nettype wire

FILE: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: base ** exponent mod modulus
// Right-to-left square-and-multiply over a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Write modulus (index 0) and exponent (index 1) through cfg_we/cfg_index/
//   cfg_data while the block is idle; only the low WIDTH bits are kept.
//   Present a base word on in_base with in_valid; it is taken on a clock edge
//   with in_valid high and in_stall low. One power word follows on out_power
//   with out_valid, taken when out_stall is low.
// Operation:
//   A zero modulus, base or exponent gives 0 without running the multiplier.
//   Otherwise the base is first reduced, then every exponent bit above the
//   lowest costs a square plus a multiply when the bit is set. The bit-serial
//   multiplier takes one operand bit a cycle; one word is in work at a time.
// Reset and stall:
//   rst_n (synchronous, active low) clears both registers to zero and empties
//   the block. A finished word waits in the output register while out_stall
//   is high; the next base word is still accepted meanwhile, and a second
//   finished word holds in the sequencer until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire mxp_pkg::cfg_idx_t  cfg_index,
  input  wire mxp_pkg::field_t    cfg_data,
  // input words
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mxp_pkg::field_t    in_base,
  // result words
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mxp_pkg::field_t         out_power
);

  import mxp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam int unsigned TW    = WIDTH + 2;

  typedef logic [WIDTH-1:0] val_t;

  // configuration registers
  val_t       m_r, e_r;

  // sequencer state
  mxp_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  val_t       x_r, x_nxt;       // raw base, for the exponent-of-one case
  val_t       sq_r, sq_nxt;     // running square, reduced
  val_t       pw_r, pw_nxt;     // running power, reduced
  val_t       esh_r, esh_nxt;   // exponent bits not yet consumed
  val_t       acc_r, acc_nxt;   // multiplier accumulator
  val_t       add_r, add_nxt;   // multiplier addend
  val_t       res_r, res_nxt;   // finished word awaiting the output register
  logic       out_valid_r, out_valid_nxt;
  val_t       out_power_r, out_power_nxt;

  // operand bit line
  logic       ld;
  val_t       ld_bits;
  logic [WIDTH-1:0] chain_q;
  logic       head;

  // datapath
  val_t       one_m;
  val_t       in_x;
  val_t       esh_sh;
  logic [TW-1:0] t_sum, t_m1, t_m2, d1, d2;
  val_t       step;
  logic       last;
  logic       in_acc;
  logic       out_free;

  // --------------------------------------------------------------------------
  // Configuration registers: keep the low WIDTH bits, drop unknown indexes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= '0;
      e_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODULUS)  m_r <= cfg_data[WIDTH-1:0];
      if (cfg_index == REG_EXPONENT) e_r <= cfg_data[WIDTH-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Operand bit line: one cell per bit, the head cell feeds the multiplier
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_tail
      assign prev = 1'b0;
    end else begin : g_link
      assign prev = chain_q[i-1];
    end
    mxp_cell u_cell (
      .clk      (clk),
      .load     (ld),
      .load_bit (ld_bits[i]),
      .prev_bit (prev),
      .bit_q    (chain_q[i])
    );
  end

  assign head = chain_q[WIDTH-1];

  // --------------------------------------------------------------------------
  // Multiplier step: acc = (2*acc + head*addend) mod m, with acc, addend < m.
  // The sum stays below 3m, so at most 2m is taken off.
  // --------------------------------------------------------------------------
  assign t_sum = {1'b0, acc_r, 1'b0} + {2'b00, (head ? add_r : '0)};
  assign t_m1  = {2'b00, m_r};
  assign t_m2  = {1'b0, m_r, 1'b0};
  assign d1    = t_sum - t_m1;
  assign d2    = t_sum - t_m2;

  always_comb begin
    priority if (t_sum >= t_m2) begin
      step = d2[WIDTH-1:0];
    end else if (t_sum >= t_m1) begin
      step = d1[WIDTH-1:0];
    end else begin
      step = t_sum[WIDTH-1:0];
    end
  end

  // 1 mod m: zero for a modulus of one
  assign one_m    = (m_r == val_t'(1)) ? '0 : val_t'(1);
  assign in_x     = in_base[WIDTH-1:0];
  assign esh_sh   = esh_r >> 1;
  assign last     = (cnt_r == CNT_W'(WIDTH - 1));
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    x_r         <= x_nxt;
    sq_r        <= sq_nxt;
    pw_r        <= pw_nxt;
    esh_r       <= esh_nxt;
    acc_r       <= acc_nxt;
    add_r       <= add_nxt;
    res_r       <= res_nxt;
    out_power_r <= out_power_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r + CNT_W'(1);
    x_nxt         = x_r;
    sq_nxt        = sq_r;
    pw_nxt        = pw_r;
    esh_nxt       = esh_r;
    acc_nxt       = step;
    add_nxt       = add_r;
    res_nxt       = res_r;
    ld            = 1'b0;
    ld_bits       = '0;
    out_valid_nxt = out_valid_r;
    out_power_nxt = out_power_r;
    in_stall      = (state_r != ST_IDLE);

    // drain the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt = in_x;
          if (m_r == '0 || in_x == '0 || e_r == '0) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            // reduce the base: multiply by 1 mod m, base bits as the operand
            ld        = 1'b1;
            ld_bits   = in_x;
            acc_nxt   = '0;
            add_nxt   = one_m;
            cnt_nxt   = '0;
            state_nxt = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        if (last) begin
          sq_nxt  = step;
          pw_nxt  = e_r[0] ? step : one_m;
          esh_nxt = e_r >> 1;
          if ((e_r >> 1) == '0) begin
            // exponent of one: hand back the base unreduced
            res_nxt   = x_r;
            state_nxt = ST_DONE;
          end else begin
            ld        = 1'b1;
            ld_bits   = step;
            acc_nxt   = '0;
            add_nxt   = step;
            cnt_nxt   = '0;
            state_nxt = ST_SQUARE;
          end
        end
      end

      ST_SQUARE: begin
        if (last) begin
          sq_nxt = step;
          if (esh_r[0]) begin
            ld        = 1'b1;
            ld_bits   = pw_r;
            acc_nxt   = '0;
            add_nxt   = step;
            cnt_nxt   = '0;
            state_nxt = ST_MULT;
          end else begin
            esh_nxt = esh_sh;
            if (esh_sh == '0) begin
              res_nxt   = pw_r;
              state_nxt = ST_DONE;
            end else begin
              ld        = 1'b1;
              ld_bits   = step;
              acc_nxt   = '0;
              add_nxt   = step;
              cnt_nxt   = '0;
              state_nxt = ST_SQUARE;
            end
          end
        end
      end

      ST_MULT: begin
        if (last) begin
          pw_nxt  = step;
          esh_nxt = esh_sh;
          if (esh_sh == '0) begin
            res_nxt   = step;
            state_nxt = ST_DONE;
          end else begin
            ld        = 1'b1;
            ld_bits   = sq_r;
            acc_nxt   = '0;
            add_nxt   = sq_r;
            cnt_nxt   = '0;
            state_nxt = ST_SQUARE;
          end
        end
      end

      ST_DONE: begin
        // hold the word until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_power_nxt = FIELD_W'(res_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE || state_r == ST_SQUARE || state_r == ST_MULT)
      |-> (acc_r < m_r && add_r < m_r))
    else $error("multiplier operand not reduced");

  a_sq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQUARE || state_r == ST_MULT) |-> (sq_r < m_r && pw_r < m_r))
    else $error("square or power not reduced");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result word without a finished computation");

endmodule : modular_exponentiation

`default_nettype wire
